// ===== src/bmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the binomial coefficient modulo prime block.
package bmp_pkg;

    localparam logic [29:0] PRIME = 30'd1000000007;
    localparam logic [31:0] PRIME_X2 = 32'd2000000014;
    localparam logic [29:0] FERMAT_EXP = PRIME - 30'd2;
    localparam logic [4:0] FERMAT_EXP_MSB = 5'd29;
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME));
    localparam int MUL_LAT = 5;

    typedef struct packed {
        logic [15:0] total_count;
        logic [15:0] choose_count;
    } query_t;

    typedef struct packed {
        logic [29:0] coefficient;
        logic        in_range;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [29:0] a;
        logic [29:0] b;
    } mul_op_t;

    typedef struct packed {
        logic        valid;
        logic [29:0] value;
    } mul_res_t;

endpackage

// ===== src/binomial_mod_prime_core.sv =====
`timescale 1ns / 1ps
// Top level of the binomial coefficient modulo 1000000007 core.
// After reset the core holds busy high while it fills the factorial table and the
// inverse factorial table; each table entry waits on one pass through the five-stage
// modular multiplier. Once busy falls it stays low and a query word is taken on
// every cycle that start is high. Each query yields one result word, shown on
// result for one cycle with done high; the receiver must take it then.
// Queries with r greater than n, or n at or beyond TABLE_DEPTH, return in_range 0
// and coefficient 0.
module binomial_mod_prime_core #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bmp_pkg::query_t   query,
    output logic              done,
    output bmp_pkg::result_t  result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
    localparam int FLAG_LAT = 2 * bmp_pkg::MUL_LAT;

    localparam logic [1:0] ST_FACT = 2'd0;
    localparam logic [1:0] ST_POW  = 2'd1;
    localparam logic [1:0] ST_INV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic PH_SQ  = 1'b0;
    localparam logic PH_MUL = 1'b1;

    logic [29:0] fact_mem [TABLE_DEPTH];
    logic [29:0] inv_mem  [TABLE_DEPTH];

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [29:0]   acc_reg, acc_next;
    logic [29:0]   base_reg, base_next;
    logic [4:0]    bit_reg, bit_next;
    logic          phase_reg, phase_next;
    logic          pend_reg, pend_next;

    logic fact_we;
    logic inv_we;

    bmp_pkg::mul_op_t  init_op;
    bmp_pkg::mul_op_t  m1_op;
    bmp_pkg::mul_op_t  m2_op;
    bmp_pkg::mul_res_t m1_res;
    bmp_pkg::mul_res_t m2_res;

    logic          accept;
    logic          in_range;
    logic [15:0]   diff;
    logic [AW-1:0] n_addr;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] d_addr;

    logic        q_valid_reg;
    logic        q_flag_reg;
    logic [29:0] fact_rd_reg;
    logic [29:0] invr_rd_reg;
    logic [29:0] invd_rd_reg;
    logic [29:0] invd_dly_reg [bmp_pkg::MUL_LAT];
    logic        flag_dly_reg [FLAG_LAT];

    logic             done_reg;
    bmp_pkg::result_t result_reg;

    assign busy   = (state_reg != ST_DONE);
    assign accept = start && !busy;
    assign diff   = query.total_count - query.choose_count;
    assign n_addr = AW'(query.total_count);
    assign r_addr = AW'(query.choose_count);
    assign d_addr = AW'(diff);
    assign in_range = (query.choose_count <= query.total_count) &&
                      ({16'd0, query.total_count} < DEPTH_W);

    // Init sequencer: forward factorial pass, one Fermat inversion, backward pass.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        bit_next   = bit_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        init_op    = '0;
        fact_we    = 1'b0;
        inv_we     = 1'b0;
        unique case (state_reg)
            ST_FACT:
            begin
                if (!pend_reg)
                begin
                    fact_we = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_POW;
                        base_next  = acc_reg;
                        acc_next   = 30'd1;
                        bit_next   = bmp_pkg::FERMAT_EXP_MSB;
                        phase_next = PH_SQ;
                    end
                    else
                    begin
                        init_op.valid = 1'b1;
                        init_op.a     = acc_reg;
                        init_op.b     = 30'(idx_reg) + 30'd1;
                        idx_next      = idx_reg + AW'(1);
                        pend_next     = 1'b1;
                    end
                end
                else if (m1_res.valid)
                begin
                    acc_next  = m1_res.value;
                    pend_next = 1'b0;
                end
            end
            ST_POW:
            begin
                if (!pend_reg)
                begin
                    init_op.valid = 1'b1;
                    init_op.a     = acc_reg;
                    init_op.b     = (phase_reg == PH_SQ) ? acc_reg : base_reg;
                    pend_next     = 1'b1;
                end
                else if (m1_res.valid)
                begin
                    acc_next  = m1_res.value;
                    pend_next = 1'b0;
                    if ((phase_reg == PH_SQ) && bmp_pkg::FERMAT_EXP[bit_reg])
                    begin
                        phase_next = PH_MUL;
                    end
                    else
                    begin
                        phase_next = PH_SQ;
                        if (bit_reg == 5'd0)
                        begin
                            state_next = ST_INV;
                        end
                        else
                        begin
                            bit_next = bit_reg - 5'd1;
                        end
                    end
                end
            end
            ST_INV:
            begin
                if (!pend_reg)
                begin
                    inv_we = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        init_op.valid = 1'b1;
                        init_op.a     = acc_reg;
                        init_op.b     = 30'(idx_reg);
                        idx_next      = idx_reg - AW'(1);
                        pend_next     = 1'b1;
                    end
                end
                else if (m1_res.valid)
                begin
                    acc_next  = m1_res.value;
                    pend_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                state_next = ST_FACT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FACT;
            idx_reg     <= '0;
            acc_reg     <= 30'd1;
            base_reg    <= 30'd1;
            bit_reg     <= bmp_pkg::FERMAT_EXP_MSB;
            phase_reg   <= PH_SQ;
            pend_reg    <= 1'b0;
            q_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            base_reg    <= base_next;
            bit_reg     <= bit_next;
            phase_reg   <= phase_next;
            pend_reg    <= pend_next;
            q_valid_reg <= accept;
            done_reg    <= m2_res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[idx_reg] <= acc_reg;
        end
        if (accept)
        begin
            fact_rd_reg <= fact_mem[n_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[idx_reg] <= acc_reg;
        end
        if (accept)
        begin
            invr_rd_reg <= inv_mem[r_addr];
            invd_rd_reg <= inv_mem[d_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_flag_reg <= in_range;
        end
        invd_dly_reg[0] <= invd_rd_reg;
        for (int k = 1; k < bmp_pkg::MUL_LAT; k++)
        begin
            invd_dly_reg[k] <= invd_dly_reg[k-1];
        end
        flag_dly_reg[0] <= q_flag_reg;
        for (int k = 1; k < FLAG_LAT; k++)
        begin
            flag_dly_reg[k] <= flag_dly_reg[k-1];
        end
        result_reg.in_range    <= flag_dly_reg[FLAG_LAT-1];
        result_reg.coefficient <= flag_dly_reg[FLAG_LAT-1] ? m2_res.value : 30'd0;
    end

    always_comb
    begin
        if (state_reg == ST_DONE)
        begin
            m1_op.valid = q_valid_reg;
            m1_op.a     = fact_rd_reg;
            m1_op.b     = invr_rd_reg;
        end
        else
        begin
            m1_op = init_op;
        end
        m2_op.valid = m1_res.valid && (state_reg == ST_DONE);
        m2_op.a     = m1_res.value;
        m2_op.b     = invd_dly_reg[bmp_pkg::MUL_LAT-1];
    end

    bmp_modmul u_mul_first (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (m1_op),
        .res   (m1_res)
    );

    bmp_modmul u_mul_second (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (m2_op),
        .res   (m2_res)
    );

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result word delivered while tables are still being built.");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(2 * bmp_pkg::MUL_LAT + 2) done)
        else $error("Query word did not produce a result at the expected cycle.");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.in_range) |-> (result.coefficient == 30'd0))
        else $error("Out-of-range query returned a nonzero coefficient.");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.coefficient < bmp_pkg::PRIME))
        else $error("Coefficient is not fully reduced modulo the prime.");
`endif

endmodule

// ===== src/bmp_modmul.sv =====
`timescale 1ns / 1ps
// Five-stage pipelined multiplier modulo the prime, using Barrett reduction.
module bmp_modmul (
    input  logic              clk,
    input  logic              rst_n,
    input  bmp_pkg::mul_op_t  op,
    output bmp_pkg::mul_res_t res
);

    logic [bmp_pkg::MUL_LAT-1:0] valid_reg;
    logic [59:0]                 prod_reg;
    logic [61:0]                 quot_reg;
    logic [31:0]                 low1_reg;
    logic [31:0]                 low2_reg;
    logic [31:0]                 sub_reg;
    logic [31:0]                 rem_reg;
    logic [29:0]                 out_reg;
    logic [29:0]                 out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[bmp_pkg::MUL_LAT-2:0], op.valid};
        end
    end

    always_comb
    begin
        if (rem_reg >= bmp_pkg::PRIME_X2)
        begin
            out_next = 30'(rem_reg - bmp_pkg::PRIME_X2);
        end
        else if (rem_reg >= {2'b00, bmp_pkg::PRIME})
        begin
            out_next = 30'(rem_reg - {2'b00, bmp_pkg::PRIME});
        end
        else
        begin
            out_next = rem_reg[29:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {30'd0, op.a} * {30'd0, op.b};
        quot_reg <= {31'd0, prod_reg[59:29]} * {31'd0, bmp_pkg::BARRETT_MU};
        low1_reg <= prod_reg[31:0];
        sub_reg  <= 32'({31'd0, quot_reg[61:31]} * {32'd0, bmp_pkg::PRIME});
        low2_reg <= low1_reg;
        rem_reg  <= low2_reg - sub_reg;
        out_reg  <= out_next;
    end

    assign res.valid = valid_reg[bmp_pkg::MUL_LAT-1];
    assign res.value = out_reg;

endmodule
